FILE: design/ptse_pkg.sv
// ----------------------------------------------------------------------------
// ptse_pkg: shared types and codes for the pattern table search block
// Action and status codes and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
`default_nettype none
package ptse_pkg;
  localparam int ActW    = 2;
  localparam int SlotW   = 10;
  localparam int PatW    = 64;
  localparam int LabelW  = 8;
  localparam int CountW  = 32;
  localparam int StatW   = 2;
  localparam int CntRegW = 11;

  typedef logic [ActW-1:0]   action_t;
  typedef logic [StatW-1:0]  status_t;
  typedef logic [CountW-1:0] count_t;

  localparam action_t ACT_WRITE  = 2'd0;
  localparam action_t ACT_SEARCH = 2'd1;
  localparam action_t ACT_ERROR  = 2'd2;

  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_MISS    = 2'd1;
  localparam status_t STAT_NO_FREQ = 2'd2;

  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_FREQ_INFO   = 1'b1;

  localparam logic [LabelW-1:0] LABEL_ONE = 8'd1;
endpackage
`default_nettype wire

FILE: design/ptse_if.sv
// ----------------------------------------------------------------------------
// ptse_in_if / ptse_out_if: request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptse_in_if import ptse_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [SlotW-1:0]  slot;
  logic [PatW-1:0]   pattern;
  logic [LabelW-1:0] label;
  count_t            occurrences;
  count_t            ones_count;
  modport source (output valid, action, slot, pattern, label, occurrences, ones_count,
                  input ready);
  modport sink   (input valid, action, slot, pattern, label, occurrences, ones_count,
                  output ready);
endinterface

interface ptse_out_if import ptse_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SlotW-1:0]  found_slot;
  logic [LabelW-1:0] found_label;
  count_t            error_sum;
  count_t            total_count;
  modport source (output valid, status, found_slot, found_label, error_sum, total_count,
                  input ready);
  modport sink   (input valid, status, found_slot, found_label, error_sum, total_count,
                  output ready);
endinterface
`default_nettype wire

FILE: design/pattern_table_search_and_error.sv
// ----------------------------------------------------------------------------
// pattern_table_search_and_error: sorted pattern table with search and error
// Entries live in one RAM; search probes it by bisection, error walks it.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// in_ch    in   valid/ready   action, slot, pattern, label, occurrences, ones_count
// out_ch   out  valid/ready   status, found_slot, found_label, error_sum, total_count
// cfg_*    in   cfg_we only   cfg_index, cfg_wdata
//
// Write: RAM write, then result. Search: each RAM probe passes a probe state and a compare
// state (registered read). Error: one RAM read per entry, summed as the reads return.
// Synchronous reset clears control, running total and config; RAM is not cleared.
// A result waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module pattern_table_search_and_error import ptse_pkg::*; #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int PATTERN_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ptse_in_if.sink                 in_ch,
  ptse_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CntRegW-1:0] cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;
  localparam int EW = PATTERN_BITS + LabelW + 2 * CountW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPROBE = 3'd1;
  localparam logic [2:0] ST_SCMP   = 3'd2;
  localparam logic [2:0] ST_EWALK  = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CntRegW-1:0]      entry_count_r;
  logic                    freq_info_r;
  count_t                  total_r, total_nxt;
  logic [PATTERN_BITS-1:0] pat_r, pat_nxt;
  logic [NW-1:0]           lo_r, lo_nxt, hx_r, hx_nxt, idx_r, idx_nxt;
  logic [AW-1:0]           mid_r, mid_nxt;
  logic                    pend_r, pend_nxt;
  count_t                  esum_r, esum_nxt;
  status_t                 rstat_r, rstat_nxt;
  logic [SlotW-1:0]        rslot_r, rslot_nxt;
  logic [LabelW-1:0]       rlabel_r, rlabel_nxt;
  logic                    ovalid_r, ovalid_nxt;
  status_t                 ostat_r, ostat_nxt;
  logic [SlotW-1:0]        oslot_r, oslot_nxt;
  logic [LabelW-1:0]       olabel_r, olabel_nxt;
  count_t                  oesum_r, oesum_nxt, ototal_r, ototal_nxt;

  logic                    in_acc, ram_we, out_free;
  logic [NW-1:0]           n_valid;
  logic [NW:0]             mid_sum;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic [PATTERN_BITS-1:0] rd_pat;
  logic [LabelW-1:0]       rd_label;
  count_t                  rd_occ, rd_ones, err_term;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_r || out_ch.ready;
  assign n_valid  = (32'(entry_count_r) > TABLE_DEPTH) ? NW'(TABLE_DEPTH)
                                                       : NW'(entry_count_r);
  assign ram_we   = in_acc && (in_ch.action == ACT_WRITE) &&
                    (32'(in_ch.slot) < TABLE_DEPTH);
  assign ram_wdata = {in_ch.pattern[PATTERN_BITS-1:0], in_ch.label,
                      in_ch.occurrences, in_ch.ones_count};
  assign {rd_pat, rd_label, rd_occ, rd_ones} = ram_rdata;
  assign err_term = (rd_label == LABEL_ONE) ? (rd_occ - rd_ones) : rd_ones;
  // floor((lo + hi) / 2) with hx = hi + 1
  assign mid_sum  = (NW + 1)'(lo_r) + (NW + 1)'(hx_r) - (NW + 1)'(1);
  assign ram_raddr = (state_r == ST_EWALK) ? idx_r[AW-1:0] : mid_sum[AW:1];

  ptse_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_ch.slot)),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = ovalid_r;
  assign out_ch.status      = ostat_r;
  assign out_ch.found_slot  = oslot_r;
  assign out_ch.found_label = olabel_r;
  assign out_ch.error_sum   = oesum_r;
  assign out_ch.total_count = ototal_r;

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    pat_nxt    = pat_r;
    lo_nxt     = lo_r;
    hx_nxt     = hx_r;
    idx_nxt    = idx_r;
    mid_nxt    = mid_r;
    pend_nxt   = 1'b0;
    esum_nxt   = esum_r;
    rstat_nxt  = rstat_r;
    rslot_nxt  = rslot_r;
    rlabel_nxt = rlabel_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    oslot_nxt  = oslot_r;
    olabel_nxt = olabel_r;
    oesum_nxt  = oesum_r;
    ototal_nxt = ototal_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pat_nxt    = in_ch.pattern[PATTERN_BITS-1:0];
          rstat_nxt  = STAT_OK;
          rslot_nxt  = '0;
          rlabel_nxt = '0;
          esum_nxt   = '0;
          lo_nxt     = '0;
          hx_nxt     = n_valid;
          idx_nxt    = '0;
          state_nxt  = ST_FIN;
          if (ram_we) begin
            total_nxt = total_r + in_ch.occurrences;
          end
          if (in_ch.action == ACT_SEARCH) begin
            rstat_nxt = STAT_MISS;
            state_nxt = ST_SPROBE;
          end else if (in_ch.action == ACT_ERROR) begin
            if (freq_info_r) begin
              state_nxt = ST_EWALK;
            end else begin
              rstat_nxt = STAT_NO_FREQ;
            end
          end
        end
      end
      ST_SPROBE: begin
        if (lo_r < hx_r) begin
          mid_nxt   = mid_sum[AW:1];
          state_nxt = ST_SCMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCMP: begin
        state_nxt = ST_SPROBE;
        if (pat_r == rd_pat) begin
          rstat_nxt  = STAT_OK;
          rslot_nxt  = SlotW'(mid_r);
          rlabel_nxt = rd_label;
          state_nxt  = ST_FIN;
        end else if (pat_r > rd_pat) begin
          lo_nxt = NW'(mid_r) + NW'(1);
        end else begin
          hx_nxt = NW'(mid_r);
        end
      end
      ST_EWALK: begin
        if (pend_r) begin
          esum_nxt = esum_r + err_term;
        end
        if (idx_r < n_valid) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + NW'(1);
        end else if (!pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = rstat_r;
          oslot_nxt  = rslot_r;
          olabel_nxt = rlabel_r;
          oesum_nxt  = esum_r;
          ototal_nxt = total_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      total_r       <= '0;
      entry_count_r <= '0;
      freq_info_r   <= 1'b0;
      pend_r        <= 1'b0;
      ovalid_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_ENTRY_COUNT) begin
          entry_count_r <= cfg_wdata;
        end else begin
          freq_info_r <= cfg_wdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_r    <= pat_nxt;
    lo_r     <= lo_nxt;
    hx_r     <= hx_nxt;
    idx_r    <= idx_nxt;
    mid_r    <= mid_nxt;
    esum_r   <= esum_nxt;
    rstat_r  <= rstat_nxt;
    rslot_r  <= rslot_nxt;
    rlabel_r <= rlabel_nxt;
    ostat_r  <= ostat_nxt;
    oslot_r  <= oslot_nxt;
    olabel_r <= olabel_nxt;
    oesum_r  <= oesum_nxt;
    ototal_r <= ototal_nxt;
  end

`ifndef NO_ASSERTIONS
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCMP) |-> (NW'(mid_r) >= lo_r) && (NW'(mid_r) < hx_r))
    else $error("search probe outside live range");
  a_total_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> total_r == $past(total_r) + $past(in_ch.occurrences))
    else $error("running total not updated by write");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EWALK) |-> idx_r <= n_valid)
    else $error("error walk past entry count");
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_free |=> ovalid_r && (state_r == ST_IDLE))
    else $error("finished result not moved to output");
`endif
endmodule
`default_nettype wire

FILE: design/ptse_ram.sv
// ----------------------------------------------------------------------------
// ptse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ptse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/pattern_table_search_and_error_tb.sv
// ----------------------------------------------------------------------------
// pattern_table_search_and_error_tb: self-checking bench for the pattern table
// Drives write, search, error and unused-action requests with random gaps and result stalls,
// predicts every result from a local copy of the table and the registers, and
// compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none
module pattern_table_search_and_error_tb;
  import ptse_pkg::*;

  localparam int Depth     = 1024;
  localparam int IdleLimit = 8000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [SlotW-1:0]  found_slot;
    logic [LabelW-1:0] found_label;
    count_t            error_sum;
    count_t            total_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_ENTRY_COUNT;
  logic [CntRegW-1:0] cfg_wdata = '0;

  ptse_in_if  in_ch ();
  ptse_out_if out_ch ();

  pattern_table_search_and_error u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the table and registers
  logic [PatW-1:0]   pat_tab   [Depth];
  logic [LabelW-1:0] label_tab [Depth];
  count_t            occ_tab   [Depth];
  count_t            ones_tab  [Depth];
  count_t            run_total;
  logic [CntRegW-1:0] entry_cnt;
  logic               freq_ok;

  answer_t answer_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  function automatic answer_t table_answer(action_t a, logic [SlotW-1:0] s,
                                           logic [PatW-1:0] p, logic [LabelW-1:0] l,
                                           count_t occ, count_t ones);
    answer_t r;
    int lo, hi, mid, n;
    r = '0;
    n = (entry_cnt > Depth) ? Depth : int'(entry_cnt);
    case (a)
      ACT_WRITE: begin
        pat_tab[s] = p;
        label_tab[s] = l;
        occ_tab[s] = occ;
        ones_tab[s] = ones;
        run_total = run_total + occ;
      end
      ACT_SEARCH: begin
        lo = 0;
        hi = n - 1;
        r.status = STAT_MISS;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (p == pat_tab[mid]) begin
            r.status = STAT_OK;
            r.found_slot = mid[SlotW-1:0];
            r.found_label = label_tab[mid];
            break;
          end else if (p > pat_tab[mid]) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      ACT_ERROR: begin
        if (!freq_ok) r.status = STAT_NO_FREQ;
        else for (int i = 0; i < n; i++) begin
          if (label_tab[i] == LABEL_ONE) r.error_sum += occ_tab[i] - ones_tab[i];
          else r.error_sum += ones_tab[i];
        end
      end
      default: ;
    endcase
    r.total_count = run_total;
    return r;
  endfunction

  task automatic send_req(action_t a, logic [SlotW-1:0] s, logic [PatW-1:0] p,
                          logic [LabelW-1:0] l, count_t occ, count_t ones);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= a;
    in_ch.slot <= s;
    in_ch.pattern <= p;
    in_ch.label <= l;
    in_ch.occurrences <= occ;
    in_ch.ones_count <= ones;
    do @(posedge clk); while (!in_ch.ready);
    answer_q.push_back(table_answer(a, s, p, l, occ, ones));
  endtask

  task automatic write_entry(int s, logic [PatW-1:0] p);
    send_req(ACT_WRITE, s[SlotW-1:0], p, LabelW'($urandom_range(0, 3) == 0 ? 1 : $urandom),
             $urandom, $urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_regs(int cnt, bit fq);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_wdata <= cnt[CntRegW-1:0];
    @(negedge clk);
    cfg_index <= CFG_FREQ_INFO;
    cfg_wdata <= CntRegW'(fq);
    @(negedge clk);
    cfg_we <= 1'b0;
    entry_cnt = cnt[CntRegW-1:0];
    freq_ok = fq;
  endtask

  task automatic test_directed_edges();
    logic [PatW-1:0] pats [8];
    pats = '{64'h0, 64'h1, 64'h1234, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'hA5A5_A5A5_A5A5_A5A5, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
    send_req(ACT_WRITE, 0, pats[0], 8'd0, 32'h0, 32'h0);
    send_req(ACT_WRITE, 1, pats[1], LABEL_ONE, 32'hFFFF_FFFF, 32'h0);
    send_req(ACT_WRITE, 2, pats[2], 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(ACT_WRITE, 3, pats[3], LABEL_ONE, 32'h5, 32'h9);
    for (int i = 4; i < 8; i++) write_entry(i, pats[i]);
    // empty table search misses
    send_req(ACT_SEARCH, 0, pats[0], 0, 0, 0);
    set_regs(8, 1'b0);
    send_req(ACT_SEARCH, 0, pats[0], 0, 0, 0);
    send_req(ACT_SEARCH, 0, pats[7], 0, 0, 0);
    send_req(ACT_SEARCH, 0, pats[4], 0, 0, 0);
    send_req(ACT_SEARCH, 0, 64'h2, 0, 0, 0);
    send_req(ACT_ERROR, 0, 0, 0, 0, 0);
    send_req(ACT_UNUSED, 10'h3FF, '1, 8'hFF, '1, '1);
    set_regs(8, 1'b1);
    send_req(ACT_ERROR, 0, 0, 0, 0, 0);
    set_regs(1, 1'b1);
    send_req(ACT_ERROR, 0, 0, 0, 0, 0);
    send_req(ACT_SEARCH, 0, pats[0], 0, 0, 0);
  endtask

  // fill every slot in ascending order, occasionally with duplicates
  task automatic test_fill_table();
    logic [PatW-1:0] p;
    p = 64'h0;
    for (int i = 0; i < Depth; i++) begin
      if ($urandom_range(0, 15) != 0) p = p + {32'($urandom_range(0, 1 << 21)), 32'($urandom)};
      write_entry(i, p);
    end
  endtask

  task automatic random_phase(int n_items);
    int n, k, idx;
    logic [PatW-1:0] p;
    for (int i = 0; i < n_items; i++) begin
      n = (entry_cnt > Depth) ? Depth : int'(entry_cnt);
      k = $urandom_range(0, 99);
      idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (k < 20) begin
        // mostly rewrite counts keeping the order intact
        idx = $urandom_range(0, Depth - 1);
        p = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : pat_tab[idx];
        write_entry(idx, p);
      end else if (k < 85) begin
        p = (n > 0 && $urandom_range(0, 9) < 7) ? pat_tab[idx] : {$urandom, $urandom};
        send_req(ACT_SEARCH, SlotW'($urandom), p, LabelW'($urandom), $urandom, $urandom);
      end else if (k < 97) begin
        send_req(ACT_ERROR, SlotW'($urandom), {$urandom, $urandom}, LabelW'($urandom),
                 $urandom, $urandom);
      end else begin
        send_req(ACT_UNUSED, SlotW'($urandom), {$urandom, $urandom}, LabelW'($urandom),
                 $urandom, $urandom);
      end
    end
  endtask

  task automatic test_random_phases();
    int cnt;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cnt = Depth;
        1: cnt = 2047;
        2: cnt = 0;
        default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(65, Depth) :
                        $urandom_range(1, 64);
      endcase
      set_regs(cnt, ph == 2 ? 1'b1 : 1'($urandom));
      random_phase(ph < 2 ? 12 : 20);
    end
  endtask

  task automatic test_final_burst();
    set_regs($urandom_range(1, 40), 1'b1);
    quiet = 1'b1;
    random_phase(20);
  endtask

  // result side: random stalls, then compare against the oldest expectation
  int stall = 0;
  always @(negedge clk) begin
    if (!rst_n || quiet) out_ch.ready <= 1'b1;
    else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.found_slot, out_ch.found_label, out_ch.error_sum,
              out_ch.total_count};
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d slot %0d/%0d label %0d/%0d esum %h/%h total %h/%h",
                     want.status, got.status, want.found_slot, got.found_slot,
                     want.found_label, got.found_label, want.error_sum, got.error_sum,
                     want.total_count, got.total_count);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.slot = '0;
    in_ch.pattern = '0;
    in_ch.label = '0;
    in_ch.occurrences = '0;
    in_ch.ones_count = '0;
    out_ch.ready = 1'b1;
    run_total = '0;
    entry_cnt = '0;
    freq_ok = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      pat_tab[i] = '0;
      label_tab[i] = '0;
      occ_tab[i] = '0;
      ones_tab[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fill_table();
    test_random_phases();
    test_final_burst();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
